### rtl/pnm_pkg.sv
`default_nettype none

package pnm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int WHITE_W     = 16;
	localparam int GAIN_W      = 16;
	localparam int COEF_W      = 25;
	localparam int TAP_W       = 32;
	localparam int SUM_W       = 35;
	localparam int PINK_W      = 32;
	localparam int ACC_W       = 60;
	localparam int NCH         = 2;
	localparam int NSECT       = 6;
	localparam int SECT_IDX_W  = 3;
	localparam int STEP_W      = 5;
	localparam int SHIFT_W     = 6;
	localparam int DRAIN_CYC   = 2;
	localparam int OUT_SHIFT   = 39 - SAMPLE_BITS;
	localparam int REG_IDX_W   = 1;
	localparam int WR_DATA_W   = 16;

	localparam logic [REG_IDX_W-1:0] REG_NOISE_GAIN  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_STEREO_MODE = 1'b1;

	localparam logic [STEP_W-1:0] STEP_DELAY  = 5'd12;
	localparam logic [STEP_W-1:0] STEP_DIRECT = 5'd13;
	localparam logic [STEP_W-1:0] STEP_SCALE  = 5'd16;
	localparam logic [STEP_W-1:0] STEP_GAIN   = 5'd19;
	localparam logic [STEP_W-1:0] STEP_LAST   = 5'd19;

	localparam logic signed [COEF_W-1:0] POLE_A [NSECT] = '{
		25'sd16758090, 25'sd16665144, 25'sd16257122,
		25'sd14537458, 25'sd9227469, -25'sd12777528
	};
	localparam logic signed [COEF_W-1:0] POLE_B [NSECT] = '{
		25'sd931436, 25'sd1259565, 25'sd2581208,
		25'sd5209084, 25'sd8941454, -25'sd283501
	};
	localparam logic signed [COEF_W-1:0] C_DIRECT = 25'sd8995943;
	localparam logic signed [COEF_W-1:0] C_DELAY  = 25'sd1944916;
	localparam logic signed [COEF_W-1:0] C_SCALE  = 25'sd1845494;

	localparam logic signed [ACC_W-1:0] TAP_HI = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] TAP_LO = -TAP_HI - ACC_W'(64'sd1);
	localparam logic signed [ACC_W-1:0] SMP_HI =
		ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SMP_LO = -SMP_HI - ACC_W'(64'sd1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_left;
		logic signed [SAMPLE_BITS-1:0] sample_right;
		logic signed [WHITE_W-1:0]     white_left;
		logic signed [WHITE_W-1:0]     white_right;
	} pnm_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_left;
		logic signed [SAMPLE_BITS-1:0] out_right;
	} pnm_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_TAP,
		MUL_WHITE,
		MUL_SUM,
		MUL_GAIN
	} mul_sel_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_TAP,
		WB_DELAY,
		WB_DIRECT,
		WB_PINK,
		WB_OUT
	} wb_t;

	typedef struct packed {
		mul_sel_t                   mul;
		logic signed [COEF_W-1:0]   coef;
		logic                       acc_add;
		logic                       sh12;
		wb_t                        wb;
		logic [SECT_IDX_W-1:0]      tap;
	} uop_t;

	typedef struct packed {
		wb_t                        wb;
		logic                       ch;
		logic [SECT_IDX_W-1:0]      tap;
		logic                       acc_add;
		logic                       sh12;
	} ctl_t;

	// one channel: six section pairs, delay, direct, scale, gain
	function automatic uop_t ucode(input logic [STEP_W-1:0] step);
		uop_t                  u;
		logic [SECT_IDX_W-1:0] k;
		u = '{mul: MUL_NONE, coef: '0, acc_add: 1'b0, sh12: 1'b0, wb: WB_NONE, tap: '0};
		k = SECT_IDX_W'(step >> 1);
		if (step < STEP_W'(2 * NSECT)) begin
			u.tap = k;
			if (!step[0]) begin
				u.mul  = MUL_TAP;
				u.coef = POLE_A[k];
			end else begin
				u.mul     = MUL_WHITE;
				u.coef    = POLE_B[k];
				u.acc_add = 1'b1;
				u.sh12    = 1'b1;
				u.wb      = WB_TAP;
			end
		end else begin
			case (step)
				STEP_DELAY: begin
					u.mul  = MUL_WHITE;
					u.coef = C_DELAY;
					u.wb   = WB_DELAY;
				end
				STEP_DIRECT: begin
					u.mul  = MUL_WHITE;
					u.coef = C_DIRECT;
					u.wb   = WB_DIRECT;
				end
				STEP_SCALE: begin
					u.mul  = MUL_SUM;
					u.coef = C_SCALE;
					u.wb   = WB_PINK;
				end
				STEP_GAIN: begin
					u.mul = MUL_GAIN;
					u.wb  = WB_OUT;
				end
				default: begin
					u.mul = MUL_NONE;
				end
			endcase
		end
		return u;
	endfunction

endpackage

`default_nettype wire

### rtl/pink_noise_mixer.sv
// A new frame is taken only in idle, after the previous result is loaded into the output register.
// One shared 35x25 multiplier runs 20 steps per channel, two channels in turn,
// then the pipeline drains before the result is loaded into the output register.
// A finished beat waits in the output register while the next frame is taken.
// Reset (arst_n low, asynchronous): filter taps cleared, noise_gain 0,
// stereo_mode 1, no beat pending.
`default_nettype none

module pink_noise_mixer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                frame_valid,
	output logic                                     frame_ready,
	input  wire pnm_pkg::pnm_in_t                    frame,
	output logic                                     mix_valid,
	input  wire logic                                mix_ready,
	output pnm_pkg::pnm_out_t                        mix,
	input  wire logic                                wr_en,
	input  wire logic [pnm_pkg::REG_IDX_W-1:0]       wr_idx,
	input  wire logic [pnm_pkg::WR_DATA_W-1:0]       wr_data
);
	import pnm_pkg::*;

	state_t state_q, state_n;
	logic [STEP_W-1:0] step_q;
	logic              ch_q;
	logic              issue, load_out, take_frame;

	pnm_in_t           frame_q;
	logic [GAIN_W-1:0] gain_q;
	logic              stereo_q;

	logic signed [TAP_W-1:0]  taps_q [NCH][NSECT];
	logic signed [TAP_W-1:0]  tap6_q [NCH];
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [PINK_W-1:0] pink_q;

	uop_t                     uop;
	logic signed [WHITE_W-1:0] white_sel;
	logic signed [SUM_W-1:0]  op_a;
	logic signed [COEF_W-1:0] op_b;
	logic signed [ACC_W-1:0]  prod;
	ctl_t                     ctl_n, ctl_s1, ctl_s2;
	logic signed [ACC_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]  acc_n, acc_s2;

	logic [SHIFT_W-1:0]            sh;
	logic signed [ACC_W-1:0]       rnd, rsv, y;
	logic signed [TAP_W-1:0]       tap_sat;
	logic signed [SAMPLE_BITS-1:0] samp, y_sat;
	logic signed [SAMPLE_BITS-1:0] res_l_q, res_r_q;

	logic     mix_valid_q;
	pnm_out_t mix_q;

	// sequencer
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:  if (frame_valid) state_n = ST_RUN;
			ST_RUN:   if (step_q == STEP_LAST && ch_q) state_n = ST_DRAIN;
			ST_DRAIN: if (step_q == STEP_W'(DRAIN_CYC - 1)) state_n = ST_HOLD;
			ST_HOLD:  if (load_out) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		frame_ready = 1'b0;
		issue       = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE:  frame_ready = 1'b1;
			ST_RUN:   issue = 1'b1;
			ST_DRAIN: ;
			ST_HOLD:  load_out = !mix_valid_q || mix_ready;
			default:  ;
		endcase
	end

	assign take_frame = frame_valid && frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			ch_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				ST_RUN: begin
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						ch_q   <= ~ch_q;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DRAIN: step_q <= step_q + STEP_W'(1);
				default: begin
					step_q <= '0;
					ch_q   <= 1'b0;
				end
			endcase
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= '0;
			stereo_q <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_NOISE_GAIN:  gain_q   <= wr_data[GAIN_W-1:0];
				REG_STEREO_MODE: stereo_q <= wr_data[0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_frame) frame_q <= frame;
	end

	// step issue: operand select and multiply
	always_comb begin
		uop       = ucode(step_q);
		white_sel = ch_q ? frame_q.white_right : frame_q.white_left;
		case (uop.mul)
			MUL_TAP: begin
				op_a = SUM_W'(taps_q[ch_q][uop.tap]);
				op_b = uop.coef;
			end
			MUL_WHITE: begin
				op_a = SUM_W'(white_sel);
				op_b = uop.coef;
			end
			MUL_SUM: begin
				op_a = sum_q;
				op_b = uop.coef;
			end
			MUL_GAIN: begin
				op_a = SUM_W'(pink_q);
				op_b = COEF_W'(signed'({1'b0, gain_q}));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		prod = op_a * op_b;

		ctl_n.wb      = issue ? uop.wb : WB_NONE;
		ctl_n.ch      = ch_q;
		ctl_n.tap     = uop.tap;
		ctl_n.acc_add = uop.acc_add;
		ctl_n.sh12    = uop.sh12;
	end

	// accumulate
	assign acc_n = (ctl_s1.acc_add ? acc_s2 : '0) + (ctl_s1.sh12 ? (prod_s1 <<< 12) : prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{wb: WB_NONE, ch: 1'b0, tap: '0, acc_add: 1'b0, sh12: 1'b0};
			ctl_s2 <= '{wb: WB_NONE, ch: 1'b0, tap: '0, acc_add: 1'b0, sh12: 1'b0};
		end else begin
			ctl_s1 <= ctl_n;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		acc_s2  <= acc_n;
	end

	// round, saturate, write back
	always_comb begin
		case (ctl_s2.wb) inside
			WB_DELAY, WB_DIRECT: sh = SHIFT_W'(12);
			WB_OUT:              sh = SHIFT_W'(OUT_SHIFT);
			default:             sh = SHIFT_W'(24);
		endcase
		rnd = ACC_W'(64'sd1) <<< (sh - SHIFT_W'(1));
		rsv = (acc_s2 + rnd) >>> sh;

		if (rsv > TAP_HI)      tap_sat = TAP_W'(TAP_HI);
		else if (rsv < TAP_LO) tap_sat = TAP_W'(TAP_LO);
		else                   tap_sat = TAP_W'(rsv);

		samp = ctl_s2.ch ? frame_q.sample_right : frame_q.sample_left;
		y    = rsv + ACC_W'(samp);
		if (y > SMP_HI)      y_sat = SAMPLE_BITS'(SMP_HI);
		else if (y < SMP_LO) y_sat = SAMPLE_BITS'(SMP_LO);
		else                 y_sat = SAMPLE_BITS'(y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				tap6_q[c] <= '0;
				for (int k = 0; k < NSECT; k++) taps_q[c][k] <= '0;
			end
		end else begin
			case (ctl_s2.wb)
				WB_TAP:   taps_q[ctl_s2.ch][ctl_s2.tap] <= tap_sat;
				WB_DELAY: tap6_q[ctl_s2.ch] <= tap_sat;
				default:  ;
			endcase
		end
	end

	// old delay term seeds the sum on the first section
	always_ff @(posedge clk) begin
		case (ctl_s2.wb)
			WB_TAP: begin
				sum_q <= ((ctl_s2.tap == '0) ? SUM_W'(tap6_q[ctl_s2.ch]) : sum_q)
					+ SUM_W'(tap_sat);
			end
			WB_DIRECT: sum_q <= sum_q + SUM_W'(rsv);
			WB_PINK:   pink_q <= PINK_W'(rsv);
			WB_OUT: begin
				if (ctl_s2.ch) res_r_q <= y_sat;
				else           res_l_q <= y_sat;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_valid_q <= 1'b0;
		end else if (load_out) begin
			mix_valid_q <= 1'b1;
		end else if (mix_ready) begin
			mix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mix_q.out_left  <= res_l_q;
			mix_q.out_right <= stereo_q ? res_r_q : '0;
		end
	end

	assign mix_valid = mix_valid_q;
	assign mix       = mix_q;

endmodule

`default_nettype wire

### rtl/pnm_checker.sv
`default_nettype none

module pnm_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              frame_valid,
	input wire logic              frame_ready,
	input wire logic              mix_valid,
	input wire logic              mix_ready,
	input wire pnm_pkg::pnm_out_t mix
);
	logic [1:0] pend_q;
	logic       in_beat, out_beat;

	assign in_beat  = frame_valid && frame_ready;
	assign out_beat = mix_valid && mix_ready;

	// frames taken but whose beat is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
		end
	end

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !frame_ready)
		else $error("frame_ready high in the cycle after a frame beat");

	a_mix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && !mix_ready |=> mix_valid && $stable(mix))
		else $error("stalled mix beat changed or dropped");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid |-> pend_q != 2'd0)
		else $error("mix beat with no frame outstanding");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3 && (!frame_ready || pend_q != 2'd2))
		else $error("too many frames outstanding");

endmodule

bind pink_noise_mixer pnm_checker u_pnm_checker (.*);

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pnm_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES  = 600;
	localparam int TAIL_CYCLES  = 60;

	localparam longint DECAY_Q24 [6] = '{
		16758090, 16665144, 16257122, 14537458, 9227469, -12777528
	};
	localparam longint DRIVE_Q24 [6] = '{
		931436, 1259565, 2581208, 5209084, 8941454, -283501
	};
	localparam longint DIRECT_Q24 = 8995943;
	localparam longint DELAY_Q24  = 1944916;
	localparam longint SCALE_Q24  = 1845494;
	localparam longint TAP_MAX    = 64'sd2147483647;
	localparam longint TAP_MIN    = -64'sd2147483648;
	localparam longint SMP_MAX    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SMP_MIN    = -(64'sd1 <<< (SAMPLE_BITS - 1));

	class mix_scoreboard;
		int                       taps [14];
		logic [GAIN_W-1:0]        gain;
		logic                     stereo;
		pnm_out_t                 due_mix [$];
		int                       errors;

		function new();
			foreach (taps[i]) taps[i] = 0;
			gain   = '0;
			stereo = 1'b1;
			errors = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [WR_DATA_W-1:0] data);
			case (idx)
				REG_NOISE_GAIN:  gain = data;
				REG_STEREO_MODE: stereo = data[0];
				default: ;
			endcase
		endfunction

		static function longint rnd_shift(longint x, int n);
			return (x + (longint'(1) <<< (n - 1))) >>> n;
		endfunction

		static function int sat_tap(longint x);
			if (x > TAP_MAX) begin
				return int'(TAP_MAX);
			end
			if (x < TAP_MIN) begin
				return int'(TAP_MIN);
			end
			return int'(x);
		endfunction

		// one channel of the six-pole filter and delay tap plus the mix into the sample
		function logic signed [SAMPLE_BITS-1:0] mix_channel(int base, longint smp, longint w);
			longint acc, sum, pink, noise, y;
			sum = 0;
			for (int k = 0; k < 6; k++) begin
				acc = DECAY_Q24[k] * longint'(taps[base + k]) + w * DRIVE_Q24[k] * 4096;
				taps[base + k] = sat_tap(rnd_shift(acc, 24));
				sum += taps[base + k];
			end
			sum += taps[base + 6];
			sum += rnd_shift(w * DIRECT_Q24, 12);
			taps[base + 6] = sat_tap(rnd_shift(w * DELAY_Q24, 12));
			pink  = rnd_shift(sum * SCALE_Q24, 24);
			noise = rnd_shift(pink * longint'(gain), 39 - SAMPLE_BITS);
			y     = smp + noise;
			if (y > SMP_MAX) begin
				y = SMP_MAX;
			end
			if (y < SMP_MIN) begin
				y = SMP_MIN;
			end
			return SAMPLE_BITS'(y);
		endfunction

		function void note_frame(pnm_in_t f);
			pnm_out_t                      e;
			logic signed [SAMPLE_BITS-1:0] right;
			e.out_left  = mix_channel(0, f.sample_left, f.white_left);
			right       = mix_channel(7, f.sample_right, f.white_right);
			e.out_right = stereo ? right : '0;
			due_mix.push_back(e);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%0t: %s", $time, msg);
			end
		endfunction

		function void check_mix(pnm_out_t got);
			pnm_out_t e;
			if (due_mix.size() == 0) begin
				flag($sformatf("mix beat with nothing due: left %0d right %0d",
					got.out_left, got.out_right));
				return;
			end
			e = due_mix.pop_front();
			if (got.out_left !== e.out_left) begin
				flag($sformatf("out_left expected %0d, got %0d", e.out_left, got.out_left));
			end
			if (got.out_right !== e.out_right) begin
				flag($sformatf("out_right expected %0d, got %0d", e.out_right, got.out_right));
			end
		endfunction
	endclass

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   frame_valid = 1'b0;
	logic                   frame_ready;
	pnm_in_t                frame       = '0;
	logic                   mix_valid;
	logic                   mix_ready   = 1'b0;
	pnm_out_t               mix;
	logic                   wr_en       = 1'b0;
	logic [REG_IDX_W-1:0]   wr_idx      = '0;
	logic [WR_DATA_W-1:0]   wr_data     = '0;

	mix_scoreboard sb = new();
	bit            send_quiet = 1'b0;
	bit            recv_quiet = 1'b0;
	bit            hold_req   = 1'b0;
	int            cycle_count;

	pink_noise_mixer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame      (frame),
		.mix_valid  (mix_valid),
		.mix_ready  (mix_ready),
		.mix        (mix),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic pnm_in_t frame_of(int sl, int sr, int wl, int wr);
		pnm_in_t f;
		f.sample_left  = SAMPLE_BITS'(sl);
		f.sample_right = SAMPLE_BITS'(sr);
		f.white_left   = WHITE_W'(wl);
		f.white_right  = WHITE_W'(wr);
		return f;
	endfunction

	function automatic pnm_in_t rand_frame();
		return frame_of(int'(signed'(rand_word())), int'(signed'(rand_word())),
			int'(signed'(rand_word())), int'(signed'(rand_word())));
	endfunction

	// entered and left at a falling edge
	task automatic send_frame(input pnm_in_t f);
		int gap;
		gap = pick_gap(send_quiet);
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_valid <= 1'b1;
		frame       <= f;
		do @(posedge clk); while (!frame_ready);
		sb.note_frame(f);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		frame_valid <= 1'b0;
		while (sb.due_mix.size() > 0) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [GAIN_W-1:0] gain, input logic mode);
		logic [WR_DATA_W-1:0] mode_word;
		mode_word = {15'($urandom), mode};
		wr_en   <= 1'b1;
		wr_idx  <= REG_NOISE_GAIN;
		wr_data <= gain;
		sb.set_reg(REG_NOISE_GAIN, gain);
		@(negedge clk);
		wr_idx  <= REG_STEREO_MODE;
		wr_data <= mode_word;
		sb.set_reg(REG_STEREO_MODE, mode_word);
		@(negedge clk);
		wr_en <= 1'b0;
		send_quiet = ($urandom_range(0, 3) == 0);
		recv_quiet = ($urandom_range(0, 3) == 0);
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				mix_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				stall = pick_gap(recv_quiet);
				if (stall > 0) begin
					mix_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			mix_ready <= 1'b1;
			do @(posedge clk); while (!mix_valid);
			sb.check_mix(mix);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		pnm_in_t f;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		apply_setting(16'd16384, 1'b1);
		send_frame(frame_of(0, 0, 0, 0));
		send_frame(frame_of(32767, -32768, 0, 0));
		send_frame(frame_of(-32768, 32767, 0, 0));
		send_frame(frame_of(0, 0, 32767, -32768));
		send_frame(frame_of(0, 0, -32768, 32767));
		send_frame(frame_of(32767, 32767, 32767, 32767));
		send_frame(frame_of(-32768, -32768, -32768, -32768));
		send_frame(frame_of(1, -1, 4096, -4096));
		send_frame(frame_of(12345, -23456, -1, 1));
		wait_drained();

		// mono, full gain: right taps still advance
		apply_setting(16'hffff, 1'b0);
		send_frame(frame_of(32767, 32767, 32767, 32767));
		send_frame(frame_of(-32768, -32768, -32768, -32768));
		send_frame(frame_of(0, 32767, 32767, -32768));
		send_frame(frame_of(100, -100, -32768, 32767));
		send_frame(frame_of(0, -32768, 0, 0));
		send_frame(frame_of(-1, 12, 1000, -1000));
		wait_drained();

		apply_setting(16'd0, 1'b1);
		send_frame(frame_of(32767, -32768, 32767, -32768));
		send_frame(frame_of(-32768, 32767, -32768, 32767));
		send_frame(frame_of(5, -5, 0, 0));
		wait_drained();

		// sustained full-scale white drives the slow taps into saturation
		apply_setting(16'($urandom_range(1, 255)), 1'b1);
		for (int i = 0; i < 420; i++) begin
			f = rand_frame();
			f.white_left  = WHITE_W'(32767 - $urandom_range(0, 7));
			f.white_right = WHITE_W'(-32768 + $urandom_range(0, 7));
			send_frame(f);
		end
		wait_drained();

		apply_setting(16'hffff, 1'($urandom));
		for (int i = 0; i < 100; i++) begin
			send_frame(rand_frame());
		end
		wait_drained();

		apply_setting(16'($urandom), 1'b0);
		for (int i = 0; i < 100; i++) begin
			if (i == 20) begin
				hold_req = 1'b1;
			end
			send_quiet = (i >= 20 && i < 60) ? 1'b1 : ($urandom_range(0, 1) == 0);
			send_frame(rand_frame());
		end
		wait_drained();

		apply_setting(16'($urandom_range(0, 4095)), 1'b1);
		for (int i = 0; i < 100; i++) begin
			if (i == 50) begin
				wait_drained();
			end
			send_frame(rand_frame());
		end
		wait_drained();

		apply_setting(16'($urandom), 1'($urandom));
		for (int i = 0; i < 100; i++) begin
			send_frame(rand_frame());
		end
		wait_drained();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.due_mix.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

### files.f
rtl/pnm_pkg.sv
rtl/pink_noise_mixer.sv
rtl/pnm_checker.sv
tb/tb.sv
